FILE: rtl/pip_pkg.sv
// Shared types and constants of the point-in-polygon test core.
`timescale 1ns / 1ps

package pip_pkg;

    // Fixed field widths of the command and configuration interfaces.
    localparam int VCOUNT_W  = 7;
    localparam int VIDX_W    = 6;
    localparam int PMODE_W   = 2;
    localparam int CFG_IDX_W = 2;

    // Command codes carried on the command field.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Projection plane codes.
    localparam logic [PMODE_W-1:0] PM_PLAIN = 2'd0;
    localparam logic [PMODE_W-1:0] PM_XY    = 2'd1;
    localparam logic [PMODE_W-1:0] PM_YZ    = 2'd2;
    localparam logic [PMODE_W-1:0] PM_XZ    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_HIGH  = 2'd3;

    // Length of the drain after the last table read, and the width of its counter.
    localparam int PIPE_DEPTH = 3;
    localparam int DRAIN_W    = 2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // write the presented vertex
        logic query;     // latch the projected point and clear the parity
        logic rd_en;     // read one vertex from the table
        logic rd_first;  // this read fetches the closing vertex of the first edge
        logic finish;    // capture the query answer
    } t_dp_cmd;

endpackage

FILE: rtl/point_in_polygon_test_core.sv
// Top level of the point-in-polygon test core: configuration registers and core wiring.
`timescale 1ns / 1ps

// Point-in-polygon test core, crossing-number parity over a stored vertex table.
//
// A transaction is offered by raising i_start with i_command and the payload; it
// is taken at the rising edge where i_start is high and o_busy is low. A load
// transaction writes one vertex (i_vertex_u, i_vertex_v) into slot i_vertex_index
// and its result strobe o_done rises on the next cycle with o_was_query low. Loads
// leave the core idle, so one can be taken every cycle.
// A query transaction projects (i_point_x, i_point_y, i_point_z) onto the plane set
// by the plane mode register and walks the polygon edges, one table read per
// cycle from a single memory read port. With n vertices in use (saturated to
// MAX_VERTICES) the core reads n + 1 vertices, drains a three-stage edge pipeline
// and strobes the answer; with n equal to zero it skips the reads and the drain
// and goes straight to the answer. o_busy is high throughout.
// Each result is shown for exactly one cycle; the receiver cannot stall it.
// Configuration registers are written via i_cfg_we, i_cfg_index and i_cfg_wdata
// only while the core is idle, a rule on the user that the core does not enforce.
// Reset clears them and the control state; the table is undefined until written.

module point_in_polygon_test_core #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic                             i_cfg_we,
    input  logic [pip_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [COORD_WIDTH-1:0]           i_cfg_wdata,
    input  logic                             i_command,
    input  logic [pip_pkg::VIDX_W-1:0]       i_vertex_index,
    input  logic signed [COORD_WIDTH-1:0]    i_vertex_u,
    input  logic signed [COORD_WIDTH-1:0]    i_vertex_v,
    input  logic signed [COORD_WIDTH-1:0]    i_point_x,
    input  logic signed [COORD_WIDTH-1:0]    i_point_y,
    input  logic signed [COORD_WIDTH-1:0]    i_point_z,
    output logic                             o_done,
    output logic                             o_inside_res,
    output logic                             o_was_query
);
    import pip_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);

    logic [VCOUNT_W-1:0]           r_vertex_count;
    logic [PMODE_W-1:0]            r_plane_mode;
    logic signed [COORD_WIDTH-1:0] r_extent_low;
    logic signed [COORD_WIDTH-1:0] r_extent_high;

    t_dp_cmd       w_cmd;
    logic [AW-1:0] w_rd_addr;

    // Configuration registers: a write lands at once, the unused high bits of the
    // write data are dropped for the narrower registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_plane_mode   <= PM_PLAIN;
            r_extent_low   <= '0;
            r_extent_high  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_wdata[VCOUNT_W-1:0];
                CFG_PLANE_MODE:   r_plane_mode   <= i_cfg_wdata[PMODE_W-1:0];
                CFG_EXTENT_LOW:   r_extent_low   <= i_cfg_wdata;
                CFG_EXTENT_HIGH:  r_extent_high  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The controller owns the sequencing and the result strobe.
    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_command      (i_command),
        .i_vertex_count (r_vertex_count),
        .o_cmd          (w_cmd),
        .o_rd_addr      (w_rd_addr),
        .o_busy         (o_busy),
        .o_done         (o_done),
        .o_was_query    (o_was_query)
    );

    // The datapath holds the vertex table and evaluates one edge per cycle.
    pip_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_rd_addr      (w_rd_addr),
        .i_vertex_index (i_vertex_index),
        .i_vertex_u     (i_vertex_u),
        .i_vertex_v     (i_vertex_v),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_plane_mode   (r_plane_mode),
        .i_extent_low   (r_extent_low),
        .i_extent_high  (r_extent_high),
        .o_inside_res   (o_inside_res)
    );

endmodule

FILE: rtl/pip_ctrl.sv
// Controller state machine: sequences loads, table reads and the answer strobe.
`timescale 1ns / 1ps

module pip_ctrl #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_command,
    input  logic [pip_pkg::VCOUNT_W-1:0] i_vertex_count,
    output pip_pkg::t_dp_cmd             o_cmd,
    output logic [$clog2(MAX_VERTICES)-1:0] o_rd_addr,
    output logic                         o_busy,
    output logic                         o_done,
    output logic                         o_was_query
);
    import pip_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [DRAIN_W-1:0] r_dcnt, n_dcnt;
    logic               r_done, n_done;
    logic               r_was_query, n_was_query;

    logic [CW-1:0] w_n_sat;
    logic [CW-1:0] w_last;
    logic [CW-1:0] w_cnt_m1;

    // Counts above the table depth saturate.
    assign w_n_sat  = (int'(i_vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                            : CW'(i_vertex_count);
    assign w_last   = r_n - CW'(1);
    assign w_cnt_m1 = r_cnt - CW'(1);

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_cnt       = r_cnt;
        n_dcnt      = r_dcnt;
        n_done      = 1'b0;
        n_was_query = r_was_query;
        o_cmd       = '0;
        o_rd_addr   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_command == CMD_LOAD) begin
                        o_cmd.load  = 1'b1;
                        n_done      = 1'b1;
                        n_was_query = 1'b0;
                    end else begin
                        o_cmd.query = 1'b1;
                        n_n         = w_n_sat;
                        n_cnt       = '0;
                        n_state     = (w_n_sat == '0) ? ST_FINISH : ST_READ;
                    end
                end
            end
            ST_READ: begin
                // The first read fetches the last vertex so that edge 0 wraps around.
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_first = (r_cnt == '0);
                o_rd_addr      = (r_cnt == '0) ? w_last[AW-1:0] : w_cnt_m1[AW-1:0];
                if (r_cnt == r_n) begin
                    n_state = ST_DRAIN;
                    n_dcnt  = '0;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            ST_DRAIN: begin
                if (r_dcnt == DRAIN_W'(PIPE_DEPTH - 1)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_dcnt = r_dcnt + DRAIN_W'(1);
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_done       = 1'b1;
                n_was_query  = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_n         <= '0;
            r_cnt       <= '0;
            r_dcnt      <= '0;
            r_done      <= 1'b0;
            r_was_query <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_cnt       <= n_cnt;
            r_dcnt      <= n_dcnt;
            r_done      <= n_done;
            r_was_query <= n_was_query;
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_was_query = r_was_query;

endmodule

FILE: rtl/pip_dp.sv
// Datapath: vertex table, point projection, edge crossing pipeline and parity.
`timescale 1ns / 1ps

module pip_dp #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pip_pkg::t_dp_cmd                   i_cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]    i_rd_addr,
    input  logic [pip_pkg::VIDX_W-1:0]         i_vertex_index,
    input  logic signed [COORD_WIDTH-1:0]      i_vertex_u,
    input  logic signed [COORD_WIDTH-1:0]      i_vertex_v,
    input  logic signed [COORD_WIDTH-1:0]      i_point_x,
    input  logic signed [COORD_WIDTH-1:0]      i_point_y,
    input  logic signed [COORD_WIDTH-1:0]      i_point_z,
    input  logic [pip_pkg::PMODE_W-1:0]        i_plane_mode,
    input  logic signed [COORD_WIDTH-1:0]      i_extent_low,
    input  logic signed [COORD_WIDTH-1:0]      i_extent_high,
    output logic                               o_inside_res
);
    import pip_pkg::*;

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int CWD = COORD_WIDTH;
    localparam int D   = COORD_WIDTH + 1;
    localparam int P   = 2 * D;

    logic signed [CWD-1:0] r_u_mem [MAX_VERTICES];
    logic signed [CWD-1:0] r_v_mem [MAX_VERTICES];

    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;

    logic signed [CWD-1:0] w_pu, w_pv, w_sw;
    logic                  w_ok;

    logic signed [CWD-1:0] r_pu, r_pv;
    logic                  r_ok;

    logic                  r_rd_valid, r_rd_first;
    logic signed [CWD-1:0] r_rd_u, r_rd_v;
    logic signed [CWD-1:0] r_prev_u, r_prev_v;

    logic                  w_edge_valid, w_cross;

    logic                  r_a_valid, r_a_cross;
    logic signed [D-1:0]   r_a_dpu, r_a_dv, r_a_duj, r_a_dpv;

    logic                  r_b_valid, r_b_cross, r_b_dv_pos;
    logic signed [P-1:0]   r_b_lhs, r_b_rhs;

    logic                  w_left;
    logic                  r_parity;
    logic                  r_inside;

    // Loads beyond the table depth write nothing.
    assign w_wr_en   = i_cmd.load && (int'(i_vertex_index) < MAX_VERTICES);
    assign w_wr_addr = AW'(i_vertex_index);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_u_mem[w_wr_addr] <= i_vertex_u;
            r_v_mem[w_wr_addr] <= i_vertex_v;
        end
        r_rd_u <= r_u_mem[i_rd_addr];
        r_rd_v <= r_v_mem[i_rd_addr];
    end

    // Projection onto the selected plane and the sweep extent test.
    always_comb begin
        case (i_plane_mode)
            PM_YZ: begin
                w_pu = i_point_y;
                w_pv = i_point_z;
                w_sw = i_point_x;
            end
            PM_XZ: begin
                w_pu = i_point_x;
                w_pv = i_point_z;
                w_sw = i_point_y;
            end
            default: begin
                w_pu = i_point_x;
                w_pv = i_point_y;
                w_sw = i_point_z;
            end
        endcase
    end

    assign w_ok = (i_plane_mode == PM_PLAIN) ||
                  ((w_sw >= i_extent_low) && (w_sw < i_extent_high));

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_pu <= w_pu;
            r_pv <= w_pv;
            r_ok <= w_ok;
        end
    end

    // Each vertex read pairs with the one read before it.
    assign w_edge_valid = r_rd_valid && !r_rd_first;
    assign w_cross      = (r_rd_v > r_pv) != (r_prev_v > r_pv);

    always_ff @(posedge i_clk) begin
        if (r_rd_valid) begin
            r_prev_u <= r_rd_u;
            r_prev_v <= r_rd_v;
        end
        r_a_cross  <= w_cross;
        r_a_dpu    <= {r_pu[CWD-1], r_pu} - {r_rd_u[CWD-1], r_rd_u};
        r_a_dv     <= {r_prev_v[CWD-1], r_prev_v} - {r_rd_v[CWD-1], r_rd_v};
        r_a_duj    <= {r_prev_u[CWD-1], r_prev_u} - {r_rd_u[CWD-1], r_rd_u};
        r_a_dpv    <= {r_pv[CWD-1], r_pv} - {r_rd_v[CWD-1], r_rd_v};
        r_b_cross  <= r_a_cross;
        r_b_dv_pos <= !r_a_dv[D-1];
        r_b_lhs    <= r_a_dpu * r_a_dv;
        r_b_rhs    <= r_a_duj * r_a_dpv;
    end

    // A crossing edge never has zero height, so the sign of dv alone picks the compare.
    assign w_left = r_b_dv_pos ? (r_b_lhs < r_b_rhs) : (r_b_lhs > r_b_rhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_rd_first <= 1'b0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_parity   <= 1'b0;
            r_inside   <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.rd_en;
            r_rd_first <= i_cmd.rd_first;
            r_a_valid  <= w_edge_valid;
            r_b_valid  <= r_a_valid;
            if (i_cmd.query) begin
                r_parity <= 1'b0;
            end else if (r_b_valid && r_b_cross && w_left) begin
                r_parity <= !r_parity;
            end
            if (i_cmd.load) begin
                r_inside <= 1'b0;
            end else if (i_cmd.finish) begin
                r_inside <= r_parity && r_ok;
            end
        end
    end

    assign o_inside_res = r_inside;

endmodule

FILE: rtl/pip_checker.sv
// Port-level assertions for the point-in-polygon test core and their binding.
`timescale 1ns / 1ps

module pip_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_command,
    input logic o_busy,
    input logic o_done,
    input logic o_was_query,
    input logic o_inside_res
);
    import pip_pkg::*;

    // A load transaction answers on the very next cycle with a cleared result.
    a_load_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_command == CMD_LOAD)
        |=> (o_done && !o_was_query && !o_inside_res))
        else $error("load transaction did not answer on the next cycle");

    // A query transaction keeps the core busy on the following cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_command == CMD_QUERY) |=> (o_busy && !o_done))
        else $error("query transaction did not hold the core busy");

    // The answer to a query arrives as the core returns to idle.
    a_query_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_was_query) |-> (!o_busy && $past(o_busy)))
        else $error("query answer strobed while the core was not finishing");

    // After reset the core is idle and shows no result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_busy && !o_done))
        else $error("core not idle after reset");

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for the point-in-polygon test core.
`timescale 1ns / 1ps

// The testbench drives vertex loads and point queries into the core and checks
// every result against a predictor of its own. The predictor keeps its own copy
// of the vertex table and of the four configuration registers. It answers a
// query with exact crossing-number parity, using wide cross-multiplied compares.
//
// A queue of pending transactions is filled by the stimulus process. A clocked
// driver takes transactions from it in bursts of random length with random gaps
// between them. It predicts the answer of each transaction at the edge where the
// core accepts it. A clocked monitor pairs each o_done strobe with the oldest
// predicted answer. The core cannot be stalled on its result side, so the
// monitor only observes.
//
// Configuration registers are only written while the core is idle. Each set of
// four writes first waits until the pending queue is empty, every predicted
// answer has arrived and o_busy is low.

module tb;

    import pip_pkg::*;

    localparam int NUM_SLOTS      = 64;
    localparam int RANDOM_ITEMS   = 900;
    // Even a query over the full table ends well within this limit, so any stretch this long
    // without a transaction taken or answered means the core has hung.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;

    localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_TEN     = 32'sd10 <<< 16;
    localparam logic signed [31:0] Q_FIVE    = 32'sd5 <<< 16;
    localparam logic signed [31:0] Q_FOUR    = 32'sd4 <<< 16;

    typedef struct packed {
        logic                     command;
        logic [VIDX_W-1:0]        slot;
        logic signed [31:0]       vu;
        logic signed [31:0]       vv;
        logic signed [31:0]       px;
        logic signed [31:0]       py;
        logic signed [31:0]       pz;
    } t_pip_txn;

    typedef struct packed {
        logic hit;
        logic was_query;
    } t_pip_answer;

    // Clock, reset and every input of the core start from known values.
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_start        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = CFG_VERTEX_COUNT;
    logic [31:0]          i_cfg_wdata    = '0;
    logic                 i_command      = CMD_LOAD;
    logic [VIDX_W-1:0]    i_vertex_index = '0;
    logic signed [31:0]   i_vertex_u     = '0;
    logic signed [31:0]   i_vertex_v     = '0;
    logic signed [31:0]   i_point_x      = '0;
    logic signed [31:0]   i_point_y      = '0;
    logic signed [31:0]   i_point_z      = '0;
    logic                 o_busy;
    logic                 o_done;
    logic                 o_inside_res;
    logic                 o_was_query;

    always #5 i_clk = ~i_clk;

    point_in_polygon_test_core #(
        .MAX_VERTICES (NUM_SLOTS),
        .COORD_WIDTH  (32)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_command      (i_command),
        .i_vertex_index (i_vertex_index),
        .i_vertex_u     (i_vertex_u),
        .i_vertex_v     (i_vertex_v),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .o_done         (o_done),
        .o_inside_res   (o_inside_res),
        .o_was_query    (o_was_query)
    );

    // Predictor state: the vertex table as the core holds it, and the registers.
    logic signed [31:0]   poly_u [NUM_SLOTS];
    logic signed [31:0]   poly_v [NUM_SLOTS];
    logic [VCOUNT_W-1:0]  reg_count = '0;
    logic [PMODE_W-1:0]   reg_mode  = PM_PLAIN;
    logic signed [31:0]   reg_lo    = '0;
    logic signed [31:0]   reg_hi    = '0;

    // The stimulus side keeps its own view of the table so that queries can be
    // aimed at vertex heights before the loads have even reached the core.
    logic signed [31:0]   plan_u [NUM_SLOTS];
    logic signed [31:0]   plan_v [NUM_SLOTS];

    t_pip_txn    txn_q[$];
    t_pip_answer answer_q[$];
    t_pip_txn    cur_txn;

    int items_queued  = 0;
    int loads_checked = 0;
    int queries_taken = 0;
    int inside_seen   = 0;
    int settings_used = 0;
    int fail_count    = 0;
    int gap_left      = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;

    // Crossing-number parity of (pu, pv) against the first vertices in use.
    // The crossing point of an edge is never divided out: the point lies left
    // of it when (pu - ui) * dv and (uj - ui) * (pv - vi) compare the right way
    // round for the sign of dv. Products of 34-bit differences need 68 bits.
    function automatic logic parity_inside(input logic signed [31:0] pu,
                                           input logic signed [31:0] pv);
        int                 n;
        int                 i;
        int                 j;
        logic               odd;
        logic signed [33:0] dv;
        logic signed [33:0] du_pt;
        logic signed [33:0] du_edge;
        logic signed [33:0] dv_pt;
        logic signed [67:0] lhs;
        logic signed [67:0] rhs;
        n   = (reg_count > NUM_SLOTS) ? NUM_SLOTS : int'(reg_count);
        odd = 1'b0;
        for (i = 0; i < n; i++) begin
            j = (i == 0) ? n - 1 : i - 1;
            // Half-open rule: exactly one end must lie strictly above the point.
            if ((poly_v[i] > pv) != (poly_v[j] > pv)) begin
                dv      = poly_v[j] - poly_v[i];
                du_pt   = pu - poly_u[i];
                du_edge = poly_u[j] - poly_u[i];
                dv_pt   = pv - poly_v[i];
                lhs     = du_pt * dv;
                rhs     = du_edge * dv_pt;
                if ((dv > 0) ? (lhs < rhs) : (lhs > rhs)) begin
                    odd = ~odd;
                end
            end
        end
        return odd;
    endfunction

    // Works out the answer of one accepted transaction and files it.
    function automatic void predict_answer(input t_pip_txn t);
        t_pip_answer        a;
        logic signed [31:0] pu;
        logic signed [31:0] pv;
        logic signed [31:0] sweep;
        logic               in_extent;
        if (t.command == CMD_LOAD) begin
            poly_u[t.slot] = t.vu;
            poly_v[t.slot] = t.vv;
            a.hit          = 1'b0;
            a.was_query    = 1'b0;
        end else begin
            case (reg_mode)
                PM_YZ: begin
                    pu = t.py; pv = t.pz; sweep = t.px;
                end
                PM_XZ: begin
                    pu = t.px; pv = t.pz; sweep = t.py;
                end
                default: begin
                    pu = t.px; pv = t.py; sweep = t.pz;
                end
            endcase
            // Plain 2D mode ignores the sweep axis altogether.
            in_extent   = (reg_mode == PM_PLAIN) || (sweep >= reg_lo && sweep < reg_hi);
            a.hit       = in_extent && parity_inside(pu, pv);
            a.was_query = 1'b1;
        end
        answer_q.push_back(a);
    endfunction

    // Driver. A transaction stays on the ports with i_start high until the
    // core takes it; only then is the next one considered. Bursts end in a
    // random gap, and now and then a long burst runs with no gaps at all.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start    <= 1'b0;
            gap_left    = 0;
            burst_left  = 0;
        end else begin
            if (i_start && !o_busy) begin
                predict_answer(cur_txn);
                if (cur_txn.command == CMD_LOAD) begin
                    loads_checked++;
                end else begin
                    queries_taken++;
                end
            end
            if (!(i_start && o_busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_start <= 1'b0;
                end else if (txn_q.size() > 0) begin
                    cur_txn         = txn_q.pop_front();
                    i_command      <= cur_txn.command;
                    i_vertex_index <= cur_txn.slot;
                    i_vertex_u     <= cur_txn.vu;
                    i_vertex_v     <= cur_txn.vv;
                    i_point_x      <= cur_txn.px;
                    i_point_y      <= cur_txn.py;
                    i_point_z      <= cur_txn.pz;
                    i_start        <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(0, 8);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0
                                                                 : $urandom_range(1, 30);
                    end
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor and watchdog. Every strobe must meet a waiting prediction.
    always @(posedge i_clk) begin
        t_pip_answer want;
        if (i_rst_n) begin
            if (o_done) begin
                if (answer_q.size() == 0) begin
                    $error("result strobe with no transaction outstanding");
                    fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (o_inside_res !== want.hit) begin
                        $error("inside_res mismatch: expected %0b, got %0b",
                               want.hit, o_inside_res);
                        fail_count++;
                    end
                    if (o_was_query !== want.was_query) begin
                        $error("was_query mismatch: expected %0b, got %0b",
                               want.was_query, o_was_query);
                        fail_count++;
                    end
                    if (want.hit) begin
                        inside_seen++;
                    end
                end
            end
            if ((i_start && !o_busy) || o_done) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction moved for %0d cycles", WATCHDOG_LIMIT);
                $display("tb failed");
                $finish;
            end
        end
    end

    // Keeps the given number of bits of a random value, sign-extended, so that
    // coordinates fall in [-2^(bits-1), 2^(bits-1)).
    function automatic logic signed [31:0] rand_coord(input int bits);
        logic signed [31:0] r;
        r = $urandom;
        return r >>> (32 - bits);
    endfunction

    function automatic void push_load(input int slot, input logic signed [31:0] u,
                                      input logic signed [31:0] v);
        t_pip_txn t;
        t.command    = CMD_LOAD;
        t.slot       = slot[VIDX_W-1:0];
        t.vu         = u;
        t.vv         = v;
        t.px         = $urandom;
        t.py         = $urandom;
        t.pz         = $urandom;
        plan_u[slot] = u;
        plan_v[slot] = v;
        txn_q.push_back(t);
        items_queued++;
    endfunction

    // Places the in-plane point (u, v) and the sweep value on the axes that
    // the current plane mode reads. Unused vertex fields carry random bits.
    function automatic void push_query(input logic signed [31:0] u,
                                       input logic signed [31:0] v,
                                       input logic signed [31:0] sweep);
        t_pip_txn t;
        t.command = CMD_QUERY;
        t.slot    = VIDX_W'($urandom);
        t.vu      = $urandom;
        t.vv      = $urandom;
        case (reg_mode)
            PM_YZ: begin
                t.px = sweep; t.py = u; t.pz = v;
            end
            PM_XZ: begin
                t.px = u; t.py = sweep; t.pz = v;
            end
            default: begin
                t.px = u; t.py = v; t.pz = sweep;
            end
        endcase
        txn_q.push_back(t);
        items_queued++;
    endfunction

    // Returns once the core has nothing left in flight; the driver is then
    // parked with i_start low, which makes this the pause that lets every
    // outstanding result come back before the next register write.
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (txn_q.size() != 0 || i_start || answer_q.size() != 0 || o_busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_VERTEX_COUNT: reg_count = value[VCOUNT_W-1:0];
            CFG_PLANE_MODE:   reg_mode  = value[PMODE_W-1:0];
            CFG_EXTENT_LOW:   reg_lo    = value;
            default:          reg_hi    = value;
        endcase
    endtask

    task automatic set_all(input int count, input logic [PMODE_W-1:0] mode,
                           input logic signed [31:0] lo, input logic signed [31:0] hi);
        wait_idle();
        write_reg(CFG_VERTEX_COUNT, count);
        write_reg(CFG_PLANE_MODE, 32'(mode));
        write_reg(CFG_EXTENT_LOW, lo);
        write_reg(CFG_EXTENT_HIGH, hi);
        settings_used++;
    endtask

    // One random setting: a polygon of random size and scale, a plane mode and
    // an extent, then a mix of mostly queries with some stray loads. Queries
    // are aimed at vertex heights and at the extent bounds now and then, since
    // those are where the half-open rules bite.
    task automatic random_phase();
        int                 n;
        int                 nv;
        int                 bits;
        int                 nq;
        int                 k;
        int                 pick;
        logic [PMODE_W-1:0] mode;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] tmp;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] sweep;
        pick = $urandom_range(0, 19);
        case (pick)
            0:       n = 0;
            1:       n = 1;
            2:       n = 2;
            3:       n = NUM_SLOTS;
            4:       n = 127;   // above the table size, the core saturates to 64
            5, 6:    n = $urandom_range(13, 63);
            default: n = $urandom_range(3, 12);
        endcase
        nv   = (n > NUM_SLOTS) ? NUM_SLOTS : n;
        bits = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(8, 28);
        mode = PMODE_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            lo = rand_coord(bits);
            hi = lo;
        end else if (pick == 1) begin
            lo = COORD_MIN;
            hi = COORD_MAX;
        end else begin
            lo = rand_coord(bits);
            hi = rand_coord(bits);
            // Now and then the bounds stay reversed, which empties the extent.
            if (lo > hi && pick != 2) begin
                tmp = lo; lo = hi; hi = tmp;
            end
        end
        set_all(n, mode, lo, hi);
        if ($urandom_range(0, 4) != 0) begin
            for (k = 0; k < nv; k++) begin
                push_load(k, rand_coord(bits), rand_coord(bits));
            end
        end
        nq = $urandom_range(10, 40);
        for (k = 0; k < nq; k++) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                push_load($urandom_range(0, NUM_SLOTS - 1), rand_coord(bits), rand_coord(bits));
            end else begin
                u = rand_coord(bits);
                v = rand_coord(bits);
                if (pick < 6 && nv > 0) begin
                    pick = $urandom_range(0, nv - 1);
                    v    = plan_v[pick];
                    if ($urandom_range(0, 1) == 0) begin
                        u = plan_u[pick];
                    end
                end else if (pick == 6) begin
                    u = $urandom;
                    v = $urandom;
                end
                case ($urandom_range(0, 9))
                    0:       sweep = lo;
                    1:       sweep = hi;
                    2:       sweep = $urandom;
                    default: sweep = rand_coord(bits);
                endcase
                push_query(u, v, sweep);
            end
        end
    endtask

    initial begin
        int directed_items;
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight after reset no vertex is in use, so nothing can be inside.
        push_query('0, '0, '0);
        push_query(COORD_MAX, COORD_MIN, COORD_MAX);
        push_load(NUM_SLOTS - 1, COORD_MAX, COORD_MIN);
        push_load(0, -Q_TEN, -Q_TEN);
        push_load(1, Q_TEN, -Q_TEN);
        push_load(2, Q_TEN, Q_TEN);
        push_load(3, -Q_TEN, Q_TEN);

        // A 20 by 20 square about the origin in plain 2D mode: the centre, a
        // point beyond it, points on the bottom and left edges and on a corner,
        // and the coordinate extremes.
        set_all(4, PM_PLAIN, '0, '0);
        push_query('0, '0, '0);
        push_query(Q_TEN + Q_TEN, '0, '0);
        push_query('0, -Q_TEN, '0);
        push_query(-Q_TEN, '0, '0);
        push_query(Q_TEN, Q_TEN, '0);
        push_query(COORD_MIN, COORD_MIN, COORD_MAX);
        push_query(COORD_MAX, '0, COORD_MIN);

        // Degenerate polygons of one and two vertices.
        set_all(1, PM_PLAIN, '0, '0);
        push_query('0, '0, '0);
        set_all(2, PM_PLAIN, '0, '0);
        push_query('0, -Q_TEN, '0);

        // Swept modes: the lower bound is taken, the upper bound is not.
        set_all(4, PM_XY, -Q_FIVE, Q_FIVE);
        push_query('0, '0, -Q_FIVE);
        push_query('0, '0, Q_FIVE);
        set_all(4, PM_YZ, -Q_FIVE, Q_FIVE);
        push_query('0, '0, '0);
        set_all(4, PM_XZ, -Q_FIVE, Q_FIVE);
        push_query('0, '0, Q_FOUR);
        // An empty extent answers outside whatever the point.
        set_all(4, PM_XY, Q_FIVE, Q_FIVE);
        push_query('0, '0, Q_FIVE);
        // The widest extent: the most negative sweep value is in, the largest out.
        set_all(4, PM_XZ, COORD_MIN, COORD_MAX);
        push_query('0, '0, COORD_MIN);
        push_query('0, '0, COORD_MAX);
        directed_items = items_queued;

        // Fill every slot so that any vertex count reads written entries only.
        wait_idle();
        for (k = 0; k < NUM_SLOTS; k++) begin
            push_load(k, $urandom, $urandom);
        end
        while (items_queued < directed_items + RANDOM_ITEMS) begin
            random_phase();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (answer_q.size() != 0) begin
            $error("%0d results never arrived", answer_q.size());
            fail_count += answer_q.size();
        end
        $display("Covered %0d vertex loads and %0d point queries over %0d register settings,",
                 loads_checked, queries_taken, settings_used);
        $display("with %0d queries answered inside and %0d mismatches.",
                 inside_seen, fail_count);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/pip_pkg.sv
rtl/pip_ctrl.sv
rtl/pip_dp.sv
rtl/point_in_polygon_test_core.sv
rtl/pip_checker.sv
tb/tb.sv
